// ===== design/owle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package owle_pkg;

   // Request kinds.
   localparam logic [2:0] KIND_PUSH    = 3'd0;
   localparam logic [2:0] KIND_POP     = 3'd1;
   localparam logic [2:0] KIND_REPLACE = 3'd2;
   localparam logic [2:0] KIND_INSERT  = 3'd3;
   localparam logic [2:0] KIND_DELETE  = 3'd4;
   localparam logic [2:0] KIND_READ    = 3'd5;

   // Response status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int unsigned LEN_W = 9;
   localparam int unsigned POS_W = 8;
   localparam int unsigned WORD_W = 16;

   // Memory read address selection.
   localparam logic [1:0] RD_POS     = 2'd0;
   localparam logic [1:0] RD_PTR_DEC = 2'd1;
   localparam logic [1:0] RD_PTR_INC = 2'd2;

   // Memory write address and data selection.
   localparam logic [1:0] WR_LEN_WORD  = 2'd0;
   localparam logic [1:0] WR_POS_WORD  = 2'd1;
   localparam logic [1:0] WR_PTR_RDATA = 2'd2;
   localparam logic [1:0] WR_PTR_WORD  = 2'd3;

   // Pointer operations.
   localparam logic [2:0] PTR_HOLD     = 3'd0;
   localparam logic [2:0] PTR_LOAD_LEN = 3'd1;
   localparam logic [2:0] PTR_LOAD_POS = 3'd2;
   localparam logic [2:0] PTR_DEC      = 3'd3;
   localparam logic [2:0] PTR_INC      = 3'd4;

   // Length operations.
   localparam logic [1:0] LEN_HOLD = 2'd0;
   localparam logic [1:0] LEN_INC  = 2'd1;
   localparam logic [1:0] LEN_DEC  = 2'd2;

   typedef struct packed {
      logic [2:0]        kind;
      logic [POS_W-1:0]  position;
      logic [WORD_W-1:0] word_in;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [WORD_W-1:0] word_out;
      logic [LEN_W-1:0]  length;
   } rsp_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic [1:0] wr_sel;
      logic [2:0] ptr_op;
      logic [1:0] len_op;
      logic       pend_load;
      logic [1:0] pend_status;
      logic       pend_rd;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       in_range;
      logic       full;
      logic       empty;
      logic       ptr_at_pos;
      logic       dn_more;
      logic       rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== design/owle_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owle_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/owle_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owle_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire owle_pkg::stat_type stat,
   output owle_pkg::cmd_type       cmd
);

   import owle_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_UP_RD  = 3'd2;
   localparam logic [2:0] S_UP_WR  = 3'd3;
   localparam logic [2:0] S_DN_RD  = 3'd4;
   localparam logic [2:0] S_DN_WR  = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.pend_load   = 1'b1;
            cmd.pend_status = ST_OK;
            state_in        = S_RESP;
            unique case (stat.kind)
               KIND_PUSH: begin
                  if (stat.full) begin
                     cmd.pend_status = ST_FULL;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_LEN_WORD;
                     cmd.len_op = LEN_INC;
                  end
               end
               KIND_POP: begin
                  if (!stat.empty) begin
                     cmd.len_op = LEN_DEC;
                  end
               end
               KIND_REPLACE: begin
                  if (!stat.in_range) begin
                     cmd.pend_status = ST_RANGE;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_POS_WORD;
                  end
               end
               KIND_INSERT: begin
                  if (!stat.in_range) begin
                     cmd.pend_status = ST_RANGE;
                  end else if (stat.full) begin
                     cmd.pend_status = ST_FULL;
                  end else begin
                     cmd.pend_load = 1'b0;
                     cmd.ptr_op    = PTR_LOAD_LEN;
                     state_in      = S_UP_RD;
                  end
               end
               KIND_DELETE: begin
                  if (!stat.in_range) begin
                     cmd.pend_status = ST_RANGE;
                  end else begin
                     cmd.pend_load = 1'b0;
                     cmd.ptr_op    = PTR_LOAD_POS;
                     state_in      = S_DN_RD;
                  end
               end
               KIND_READ: begin
                  if (!stat.in_range) begin
                     cmd.pend_status = ST_RANGE;
                  end else begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_sel  = RD_POS;
                     cmd.pend_rd = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         S_UP_RD: begin
            // The pointer walks down from the old end; when it meets the
            // insert position the new word goes in.
            if (stat.ptr_at_pos) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_sel      = WR_PTR_WORD;
               cmd.len_op      = LEN_INC;
               cmd.pend_load   = 1'b1;
               cmd.pend_status = ST_OK;
               state_in        = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PTR_DEC;
               state_in   = S_UP_WR;
            end
         end
         S_UP_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_PTR_RDATA;
            cmd.ptr_op = PTR_DEC;
            state_in   = S_UP_RD;
         end
         S_DN_RD: begin
            if (stat.dn_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PTR_INC;
               state_in   = S_DN_WR;
            end else begin
               cmd.len_op      = LEN_DEC;
               cmd.pend_load   = 1'b1;
               cmd.pend_status = ST_OK;
               state_in        = S_RESP;
            end
         end
         S_DN_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_PTR_RDATA;
            cmd.ptr_op = PTR_INC;
            state_in   = S_DN_RD;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/owle_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owle_dp #(
   parameter int unsigned DEPTH = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire owle_pkg::req_type req_data,
   input  wire owle_pkg::cmd_type cmd,
   output owle_pkg::stat_type     stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output owle_pkg::rsp_type      rsp_data
);

   import owle_pkg::*;

   localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW  = $clog2(DEPTH + 1);
   localparam int unsigned XW  = (CW > POS_W) ? CW : POS_W;
   localparam int unsigned LXW = (CW > LEN_W) ? CW : LEN_W;

   req_type           req_ff;
   logic [CW-1:0]     len_ff;
   logic [CW-1:0]     len_in;
   logic [CW-1:0]     ptr_ff;
   logic [CW-1:0]     ptr_in;
   logic [1:0]        pend_status_ff;
   logic              pend_rd_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_ff;

   logic [XW-1:0]     pos_x;
   logic [XW-1:0]     len_x;
   logic [CW-1:0]     pos_c;
   logic [CW:0]       ptr_next_up;
   logic [LXW-1:0]    len_out_x;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   assign pos_x       = XW'(req_ff.position);
   assign len_x       = XW'(len_ff);
   assign pos_c       = pos_x[CW-1:0];
   assign ptr_next_up = {1'b0, ptr_ff} + {{CW{1'b0}}, 1'b1};

   assign stat.kind       = req_ff.kind;
   assign stat.in_range   = (pos_x < len_x);
   assign stat.full       = (len_ff == CW'(DEPTH));
   assign stat.empty      = (len_ff == '0);
   assign stat.ptr_at_pos = (ptr_ff == pos_c);
   assign stat.dn_more    = (ptr_next_up < {1'b0, len_ff});
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ram_rd_en = cmd.rd_en;
      unique case (cmd.rd_sel)
         RD_POS:     ram_rd_addr = pos_x[AW-1:0];
         RD_PTR_DEC: ram_rd_addr = AW'(ptr_ff - CW'(1));
         RD_PTR_INC: ram_rd_addr = AW'(ptr_next_up);
         default:    ram_rd_addr = pos_x[AW-1:0];
      endcase
   end

   always_comb begin
      ram_wr_en = cmd.wr_en;
      unique case (cmd.wr_sel)
         WR_LEN_WORD: begin
            ram_wr_addr = AW'(len_ff);
            ram_wr_data = req_ff.word_in;
         end
         WR_POS_WORD: begin
            ram_wr_addr = pos_x[AW-1:0];
            ram_wr_data = req_ff.word_in;
         end
         WR_PTR_RDATA: begin
            ram_wr_addr = AW'(ptr_ff);
            ram_wr_data = ram_rd_data;
         end
         default: begin
            ram_wr_addr = AW'(ptr_ff);
            ram_wr_data = req_ff.word_in;
         end
      endcase
   end

   always_comb begin
      unique case (cmd.ptr_op)
         PTR_LOAD_LEN: ptr_in = len_ff;
         PTR_LOAD_POS: ptr_in = pos_c;
         PTR_DEC:      ptr_in = ptr_ff - CW'(1);
         PTR_INC:      ptr_in = ptr_next_up[CW-1:0];
         default:      ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.len_op)
         LEN_INC: len_in = len_ff + CW'(1);
         LEN_DEC: len_in = len_ff - CW'(1);
         default: len_in = len_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // The length is already final when the response is built.
   assign len_out_x = LXW'(len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.pend_load) begin
         pend_status_ff <= cmd.pend_status;
         pend_rd_ff     <= cmd.pend_rd;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status   <= pend_status_ff;
         rsp_ff.word_out <= pend_rd_ff ? ram_rd_data : '0;
         rsp_ff.length   <= len_out_x[LEN_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   owle_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ===== design/ordered_word_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH 16-bit words held in one single-port-write,
// registered-read RAM, with a live length. Each request word gives exactly
// one response word. Push, pop, replace, read and the unused kinds pass
// from acceptance to the response register through accept, decode and
// respond, as does any request that fails its index or full check. Insert
// and delete also step through the entries that must shift: the entries
// from the position upward (insert) or above it (delete) are moved one at a
// time, each needing a RAM read and then a write. One request is in flight
// at a time; a new request is taken once the previous response has been
// placed in the output register, even if that response has not yet been
// collected. The RAM contents are not cleared at reset, as only written
// entries can ever be read back.
module ordered_word_list_engine #(
   parameter int unsigned DEPTH = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire owle_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output owle_pkg::rsp_type      rsp_data
);

   import owle_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   owle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   owle_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
